/* design/ntps_pkg.sv */
// shared types and constants for the nearest true pixel search
package ntps_pkg;

	localparam int COORD_W = 12;
	localparam int DIM_W = 13;
	localparam int Q_W = 19;
	localparam int IDX_W = 4;
	localparam int CFG_DATA_W = 16;
	localparam int DIST_W = 60;

	localparam logic [IDX_W-1:0] REG_ROWS = 4'd0;
	localparam logic [IDX_W-1:0] REG_COLS = 4'd1;
	localparam logic [IDX_W-1:0] REG_ASPECT = 4'd2;
	localparam logic [IDX_W-1:0] REG_RADIUS = 4'd3;

	localparam logic CMD_WRITE = 1'b0;
	localparam logic CMD_QUERY = 1'b1;

	typedef struct packed {
		logic [8:0] rows;
		logic [8:0] cols;
		logic [15:0] aspect;
		logic [7:0] radius;
	} cfg_t;

	typedef struct packed {
		logic wr_en;
		logic [COORD_W-1:0] wr_row;
		logic [COORD_W-1:0] wr_col;
		logic wr_bit;
		logic rd_en;
		logic [COORD_W-1:0] rd_row;
		logic [COORD_W-1:0] rd_col;
	} mem_req_t;

endpackage

/* design/ntps_if.sv */
// request, result and register write channels
interface ntps_req_if;
	logic valid;
	logic ready;
	logic command;
	logic [7:0] pixel_row;
	logic [7:0] pixel_col;
	logic pixel_value;
	logic signed [ntps_pkg::Q_W-1:0] query_x;
	logic signed [ntps_pkg::Q_W-1:0] query_y;

	modport source (output valid, command, pixel_row, pixel_col, pixel_value, query_x, query_y,
		input ready);
	modport sink (input valid, command, pixel_row, pixel_col, pixel_value, query_x, query_y,
		output ready);
endinterface

interface ntps_rsp_if;
	logic valid;
	logic ready;
	logic found;
	logic [7:0] found_row;
	logic [7:0] found_col;

	modport source (output valid, found, found_row, found_col, input ready);
	modport sink (input valid, found, found_row, found_col, output ready);
endinterface

interface ntps_cfg_if;
	logic valid;
	logic ready;
	logic [ntps_pkg::IDX_W-1:0] index;
	logic [ntps_pkg::CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

/* design/ntps_mask_mem.sv */
// pixel mask memory with clearing pass after reset
module ntps_mask_mem #(
	parameter int MAX_ROWS = 256,
	parameter int MAX_COLS = 256
) (
	input logic clk,
	input logic arst_n,
	input ntps_pkg::mem_req_t req,
	output logic rd_bit,
	output logic clearing
);
	import ntps_pkg::*;

	localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
	localparam int AW = RW + CW;
	localparam int DEPTH = 1 << AW;

	logic mem [DEPTH];
	logic [AW-1:0] clr_addr_q;
	logic clr_busy_q;
	logic rd_bit_q;
	logic [AW-1:0] wr_addr;
	logic [AW-1:0] rd_addr;

	assign wr_addr = {req.wr_row[RW-1:0], req.wr_col[CW-1:0]};
	assign rd_addr = {req.rd_row[RW-1:0], req.rd_col[CW-1:0]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_busy_q) begin
			clr_addr_q <= clr_addr_q + AW'(1);
			if (&clr_addr_q) begin
				clr_busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (clr_busy_q) begin
			mem[clr_addr_q] <= 1'b0;
		end else if (req.wr_en) begin
			mem[wr_addr] <= req.wr_bit;
		end
		if (req.rd_en) begin
			rd_bit_q <= mem[rd_addr];
		end
	end

	assign rd_bit = rd_bit_q;
	assign clearing = clr_busy_q;

endmodule

/* design/ntps_mul.sv */
// shared registered 32 by 32 multiplier
module ntps_mul (
	input logic clk,
	input logic [31:0] op_a,
	input logic [31:0] op_b,
	output logic [63:0] prod_q
);

	always_ff @(posedge clk) begin
		prod_q <= op_a * op_b;
	end

endmodule

/* design/ntps_seq.sv */
// query sequencer, window scan and distance datapath
module ntps_seq #(
	parameter int MAX_ROWS = 256,
	parameter int MAX_COLS = 256
) (
	input logic clk,
	input logic arst_n,
	ntps_req_if.sink req,
	ntps_rsp_if.source rsp,
	input ntps_pkg::cfg_t cfg_regs,
	output ntps_pkg::mem_req_t mem_req,
	input logic rd_bit,
	input logic clearing,
	output logic [31:0] mul_a,
	output logic [31:0] mul_b,
	input logic [63:0] prod
);
	import ntps_pkg::*;

	localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;

	typedef enum logic [3:0] {
		S_IDLE, S_ROUND, S_CENTER, S_CTRCHK, S_BND_A, S_BND_B, S_BND_C,
		S_SCAN, S_HIT_DX, S_DYA, S_DYR, S_DYSQ, S_CMP, S_DONE
	} state_t;

	state_t state_q;
	logic rsp_valid_q;
	logic rsp_found_q;
	logic [7:0] rsp_row_q;
	logic [7:0] rsp_col_q;

	logic signed [Q_W-1:0] qx_q;
	logic signed [Q_W-1:0] qy_q;
	logic [RW-1:0] row_q, r0_q, r1_q, r_q, br_q;
	logic [CW-1:0] col_q, c0_q, c1_q, c_q, bc_q;
	logic [20:0] dx_q;
	logic [20:0] dy8_q;
	logic [28:0] dy_q;
	logic [DIST_W-1:0] acc_q;
	logic [DIST_W-1:0] best_q;
	logic found_q;

	logic in_acc;
	logic wr_in_range;
	logic [DIM_W-1:0] nrow, ncol, maxrow, maxcol;
	logic [DIM_W-1:0] row_c, col_c, r0_c, r1_c, c0_c, c1_c;
	logic signed [13:0] r_lo, r_hi, c_lo, c_hi;
	logic signed [21:0] dxs, dys;
	logic [20:0] dx_abs, dy_abs;
	logic [37:0] dy_sum;
	logic [DIST_W-1:0] dist_sum;
	logic c_last, last;
	logic [RW-1:0] nxt_r;
	logic [CW-1:0] nxt_c;
	logic [COORD_W-1:0] br_ext, bc_ext;

	function automatic logic signed [11:0] round_even(input logic signed [Q_W-1:0] v);
		logic signed [10:0] fl;
		logic inc;
		fl = v[18:8];
		inc = (v[7:0] > 8'd128) || ((v[7:0] == 8'd128) && fl[0]);
		return {fl[10], fl} + {11'b0, inc};
	endfunction

	function automatic logic [DIM_W-1:0] clamp_dim(input logic signed [13:0] v,
		input logic [DIM_W-1:0] maxv);
		logic [DIM_W-1:0] res;
		if (v < 0) begin
			res = '0;
		end else if (v > $signed({1'b0, maxv})) begin
			res = maxv;
		end else begin
			res = v[DIM_W-1:0];
		end
		return res;
	endfunction

	assign req.ready = (state_q == S_IDLE) && !clearing;
	assign in_acc = req.valid && req.ready;
	assign wr_in_range = ({5'b0, req.pixel_row} < DIM_W'(MAX_ROWS))
		&& ({5'b0, req.pixel_col} < DIM_W'(MAX_COLS));

	always_comb begin
		if (cfg_regs.rows == 9'd0) begin
			nrow = DIM_W'(1);
		end else if ({4'b0, cfg_regs.rows} > DIM_W'(MAX_ROWS)) begin
			nrow = DIM_W'(MAX_ROWS);
		end else begin
			nrow = {4'b0, cfg_regs.rows};
		end
		if (cfg_regs.cols == 9'd0) begin
			ncol = DIM_W'(1);
		end else if ({4'b0, cfg_regs.cols} > DIM_W'(MAX_COLS)) begin
			ncol = DIM_W'(MAX_COLS);
		end else begin
			ncol = {4'b0, cfg_regs.cols};
		end
		maxrow = nrow - DIM_W'(1);
		maxcol = ncol - DIM_W'(1);
	end

	assign row_c = clamp_dim(14'(round_even(qy_q)), maxrow);
	assign col_c = clamp_dim(14'(round_even(qx_q)), maxcol);

	assign r_lo = $signed(14'(row_q)) - $signed(14'(cfg_regs.radius));
	assign r_hi = $signed(14'(row_q)) + $signed(14'(cfg_regs.radius));
	assign c_lo = $signed(14'(col_q)) - $signed(14'(cfg_regs.radius));
	assign c_hi = $signed(14'(col_q)) + $signed(14'(cfg_regs.radius));
	assign r0_c = clamp_dim(r_lo, maxrow);
	assign r1_c = clamp_dim(r_hi, maxrow);
	assign c0_c = clamp_dim(c_lo, maxcol);
	assign c1_c = clamp_dim(c_hi, maxcol);

	assign dxs = 22'(qx_q) - $signed(22'({c_q, 8'b0}));
	assign dys = 22'(qy_q) - $signed(22'({r_q, 8'b0}));
	assign dx_abs = (dxs < 0) ? 21'(-dxs) : dxs[20:0];
	assign dy_abs = (dys < 0) ? 21'(-dys) : dys[20:0];
	assign dy_sum = {1'b0, prod[36:0]} + 38'd128;
	assign dist_sum = acc_q + prod[DIST_W-1:0];

	assign c_last = (c_q == c1_q);
	assign last = c_last && (r_q == r1_q);
	assign nxt_c = c_last ? c0_q : c_q + CW'(1);
	assign nxt_r = c_last ? r_q + RW'(1) : r_q;

	assign br_ext = COORD_W'(br_q);
	assign bc_ext = COORD_W'(bc_q);

	// memory port and multiplier operands
	always_comb begin
		mem_req = '0;
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			S_IDLE: begin
				mem_req.wr_en = in_acc && (req.command == CMD_WRITE) && wr_in_range;
				mem_req.wr_row = COORD_W'(req.pixel_row);
				mem_req.wr_col = COORD_W'(req.pixel_col);
				mem_req.wr_bit = req.pixel_value;
			end
			S_CENTER: begin
				mem_req.rd_en = 1'b1;
				mem_req.rd_row = COORD_W'(row_q);
				mem_req.rd_col = COORD_W'(col_q);
			end
			S_CTRCHK: begin
				mul_a = 32'({ncol, 8'b0});
				mul_b = 32'({ncol, 8'b0});
			end
			S_BND_A: begin
				mul_a = 32'(cfg_regs.aspect);
				mul_b = 32'(nrow);
			end
			S_BND_B: begin
				mul_a = prod[31:0];
				mul_b = prod[31:0];
			end
			S_BND_C: begin
				mem_req.rd_en = 1'b1;
				mem_req.rd_row = COORD_W'(r0_q);
				mem_req.rd_col = COORD_W'(c0_q);
			end
			S_SCAN, S_CMP: begin
				mem_req.rd_en = !last && ((state_q == S_CMP) || !rd_bit);
				mem_req.rd_row = COORD_W'(nxt_r);
				mem_req.rd_col = COORD_W'(nxt_c);
			end
			S_HIT_DX: begin
				mul_a = 32'(dx_q);
				mul_b = 32'(dx_q);
			end
			S_DYA: begin
				mul_a = 32'(dy8_q);
				mul_b = 32'(cfg_regs.aspect);
			end
			S_DYSQ: begin
				mul_a = 32'(dy_q);
				mul_b = 32'(dy_q);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			rsp_valid_q <= 1'b0;
			rsp_found_q <= 1'b0;
			rsp_row_q <= '0;
			rsp_col_q <= '0;
		end else begin
			if (rsp_valid_q && rsp.ready && (state_q != S_DONE)) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_acc && (req.command == CMD_QUERY)) begin
						state_q <= S_ROUND;
					end
				end
				S_ROUND: state_q <= S_CENTER;
				S_CENTER: state_q <= S_CTRCHK;
				S_CTRCHK: state_q <= rd_bit ? S_DONE : S_BND_A;
				S_BND_A: state_q <= S_BND_B;
				S_BND_B: state_q <= S_BND_C;
				S_BND_C: state_q <= S_SCAN;
				S_SCAN: begin
					if (rd_bit) begin
						state_q <= S_HIT_DX;
					end else if (last) begin
						state_q <= S_DONE;
					end
				end
				S_HIT_DX: state_q <= S_DYA;
				S_DYA: state_q <= S_DYR;
				S_DYR: state_q <= S_DYSQ;
				S_DYSQ: state_q <= S_CMP;
				S_CMP: state_q <= last ? S_DONE : S_SCAN;
				S_DONE: begin
					if (!rsp_valid_q || rsp.ready) begin
						rsp_valid_q <= 1'b1;
						rsp_found_q <= found_q;
						rsp_row_q <= found_q ? br_ext[7:0] : 8'd0;
						rsp_col_q <= found_q ? bc_ext[7:0] : 8'd0;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (in_acc && (req.command == CMD_QUERY)) begin
					qx_q <= req.query_x;
					qy_q <= req.query_y;
				end
			end
			S_ROUND: begin
				row_q <= row_c[RW-1:0];
				col_q <= col_c[CW-1:0];
			end
			S_CTRCHK: begin
				found_q <= rd_bit;
				br_q <= rd_bit ? row_q : '0;
				bc_q <= rd_bit ? col_q : '0;
				r0_q <= r0_c[RW-1:0];
				r1_q <= r1_c[RW-1:0];
				c0_q <= c0_c[CW-1:0];
				c1_q <= c1_c[CW-1:0];
			end
			S_BND_A: acc_q <= prod[DIST_W-1:0];
			S_BND_C: begin
				best_q <= dist_sum;
				r_q <= r0_q;
				c_q <= c0_q;
			end
			S_SCAN: begin
				if (rd_bit) begin
					dx_q <= dx_abs;
					dy8_q <= dy_abs;
				end else if (!last) begin
					r_q <= nxt_r;
					c_q <= nxt_c;
				end
			end
			S_DYA: acc_q <= prod[DIST_W-1:0];
			S_DYR: dy_q <= dy_sum[36:8];
			S_CMP: begin
				if (dist_sum < best_q) begin
					best_q <= dist_sum;
					br_q <= r_q;
					bc_q <= c_q;
					found_q <= 1'b1;
				end
				if (!last) begin
					r_q <= nxt_r;
					c_q <= nxt_c;
				end
			end
			default: begin
			end
		endcase
	end

	assign rsp.valid = rsp_valid_q;
	assign rsp.found = rsp_found_q;
	assign rsp.found_row = rsp_row_q;
	assign rsp.found_col = rsp_col_q;

`ifndef NO_ASSERTIONS
	a_scan_in_window: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN) |-> (r_q >= r0_q) && (r_q <= r1_q) && (c_q >= c0_q) && (c_q <= c1_q))
		else $error("scan position left the window");
	a_best_not_rising: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CMP) |=> (best_q <= $past(best_q)))
		else $error("best distance grew");
	a_no_request_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		clearing |-> !req.ready)
		else $error("request taken during mask clear");
	a_scan_data_read: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN) |-> $past(mem_req.rd_en))
		else $error("scan without a mask read");
`endif

endmodule

/* design/nearest_true_pixel_search.sv */
// nearest true pixel search top level with register file
// pixel write: stored when taken; true rounded pixel: result after the center check
// other queries: bound setup, then a window scan with a distance step per true pixel
// a window holds up to (2*search_radius+1)^2 pixels, one mask read a cycle while scanning
// reset: registers to defaults, then a pass clearing all 2**(clog2 rows + clog2 cols)
// mask entries (65536 by default) before the first request is taken
module nearest_true_pixel_search #(
	parameter int MAX_ROWS = 256,
	parameter int MAX_COLS = 256
) (
	input logic clk,
	input logic arst_n,
	ntps_cfg_if.sink cfg,
	ntps_req_if.sink req,
	ntps_rsp_if.source rsp
);
	import ntps_pkg::*;

	cfg_t cfg_regs_q;
	mem_req_t mem_req;
	logic rd_bit;
	logic clearing;
	logic [31:0] mul_a;
	logic [31:0] mul_b;
	logic [63:0] prod;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_regs_q.rows <= 9'd256;
			cfg_regs_q.cols <= 9'd256;
			cfg_regs_q.aspect <= 16'd256;
			cfg_regs_q.radius <= 8'd8;
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.index)
				REG_ROWS: cfg_regs_q.rows <= cfg.data[8:0];
				REG_COLS: cfg_regs_q.cols <= cfg.data[8:0];
				REG_ASPECT: cfg_regs_q.aspect <= cfg.data;
				REG_RADIUS: cfg_regs_q.radius <= cfg.data[7:0];
				default: begin
				end
			endcase
		end
	end

	ntps_mask_mem #(
		.MAX_ROWS(MAX_ROWS),
		.MAX_COLS(MAX_COLS)
	) u_mem (
		.clk(clk),
		.arst_n(arst_n),
		.req(mem_req),
		.rd_bit(rd_bit),
		.clearing(clearing)
	);

	ntps_mul u_mul (
		.clk(clk),
		.op_a(mul_a),
		.op_b(mul_b),
		.prod_q(prod)
	);

	ntps_seq #(
		.MAX_ROWS(MAX_ROWS),
		.MAX_COLS(MAX_COLS)
	) u_seq (
		.clk(clk),
		.arst_n(arst_n),
		.req(req),
		.rsp(rsp),
		.cfg_regs(cfg_regs_q),
		.mem_req(mem_req),
		.rd_bit(rd_bit),
		.clearing(clearing),
		.mul_a(mul_a),
		.mul_b(mul_b),
		.prod(prod)
	);

endmodule
